// ===== design/eoq_pkg.sv =====
package eoq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int FLOOR_COUNT = 16;
    localparam int FLOOR_W = $clog2(FLOOR_COUNT);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int POS_W = 4;
    localparam int COUNT_W = 4;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_FIND   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        BTN_UP   = 2'd0,
        BTN_DOWN = 2'd1,
        BTN_CAB  = 2'd2,
        BTN_NONE = 2'd3
    } button_t;

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_FRONT     = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_CLEARED   = 3'd6,
        ST_FOUND     = 3'd7
    } status_t;

    typedef struct packed {
        opcode_t              op;
        logic [FLOOR_W-1:0]   floor;
        logic                 prio;
    } order_cmd_t;

endpackage

// ===== design/eoq_front.sv =====
module eoq_front
    import eoq_pkg::*;
(
    input  logic [1:0]         opcode,
    input  logic [FLOOR_W-1:0] floor,
    input  logic [1:0]         button,
    input  logic               moving,
    input  logic signed [1:0]  direction,
    input  logic signed [4:0]  sensor_floor,
    input  logic [FLOOR_W-1:0] last_floor,
    input  logic [FLOOR_W-1:0] dest_floor,
    output order_cmd_t         cmd
);

    logic signed [5:0] cur_eff;
    logic signed [5:0] f_s;
    logic signed [5:0] tgt_s;
    logic              dir_pos;
    logic              dir_neg;
    logic              on_way;
    logic              same_dir;

    always_comb
    begin
        if (sensor_floor == -5'sd1)
        begin
            cur_eff = $signed({2'b00, last_floor});
        end
        else
        begin
            cur_eff = 6'(sensor_floor);
        end
        f_s      = $signed({2'b00, floor});
        tgt_s    = $signed({2'b00, dest_floor});
        dir_pos  = !direction[1] && direction[0];
        dir_neg  = direction[1];
        on_way   = (dir_pos && (f_s > cur_eff) && (f_s < tgt_s)) ||
                   (dir_neg && (f_s < cur_eff) && (f_s > tgt_s));
        same_dir = (dir_pos && (button == BTN_UP)) ||
                   (dir_neg && (button == BTN_DOWN)) ||
                   (button == BTN_CAB);
        cmd.op    = opcode_t'(opcode);
        cmd.floor = floor;
        cmd.prio  = moving && (dir_pos || dir_neg) && on_way && same_dir;
    end

endmodule

// ===== design/eoq_fifo.sv =====
module eoq_fifo
    import eoq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  order_cmd_t push_cmd,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output order_cmd_t head_cmd
);

    order_cmd_t              slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   cnt_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_next;
    logic                    do_push;
    logic                    do_pop;

    assign full      = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/eoq_back.sv =====
module eoq_back
    import eoq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  order_cmd_t         cmd,
    output logic               done,
    output logic [2:0]         status,
    output logic [POS_W-1:0]   position,
    output logic               head_valid,
    output logic [FLOOR_W-1:0] head_floor,
    output logic [COUNT_W-1:0] count
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [FLOOR_W-1:0] list_reg  [QUEUE_DEPTH];
    logic [FLOOR_W-1:0] list_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               done_reg;
    status_t            status_reg;
    status_t            status_next;
    logic [POS_W-1:0]   position_reg;
    logic [POS_W-1:0]   position_next;
    logic               head_valid_reg;
    logic [FLOOR_W-1:0] head_floor_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [QUEUE_DEPTH-1:0] match;
    logic                   found;
    logic [IDX_W-1:0]       idx;
    logic                   is_full;

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            match[i] = (CNT_W'(i) < cnt_reg) && (list_reg[i] == cmd.floor);
        end
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
    end

    assign is_full = (cnt_reg >= CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        list_next     = list_reg;
        cnt_next      = cnt_reg;
        status_next   = ST_NOT_FOUND;
        position_next = found ? POS_W'(idx) : '1;
        unique case (cmd.op)
            OP_ADD:
            begin
                if (is_full)
                begin
                    status_next   = ST_FULL;
                    position_next = '1;
                end
                else if (cmd.prio)
                begin
                    status_next  = ST_FRONT;
                    list_next[0] = cmd.floor;
                    for (int i = 1; i < QUEUE_DEPTH; i++)
                    begin
                        if (found && (IDX_W'(i - 1) >= idx))
                        begin
                            list_next[i] = list_reg[i];
                        end
                        else
                        begin
                            list_next[i] = list_reg[i - 1];
                        end
                    end
                    if (!found)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else if (!found)
                begin
                    status_next = ST_APPENDED;
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (CNT_W'(i) == cnt_reg)
                        begin
                            list_next[i] = cmd.floor;
                        end
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    status_next = ST_DUPLICATE;
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    status_next = ST_REMOVED;
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (IDX_W'(i) >= idx)
                        begin
                            list_next[i] = (i + 1 < QUEUE_DEPTH) ?
                                           list_reg[(i + 1) % QUEUE_DEPTH] : '0;
                        end
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_CLEAR:
            begin
                status_next   = ST_CLEARED;
                position_next = '1;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    list_next[i] = '0;
                end
                cnt_next = '0;
            end
            OP_FIND:
            begin
                status_next = found ? ST_FOUND : ST_NOT_FOUND;
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                list_reg[i] <= '0;
            end
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd_valid;
            if (cmd_valid)
            begin
                list_reg <= list_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            status_reg     <= status_next;
            position_reg   <= position_next;
            head_valid_reg <= (cnt_next != '0);
            head_floor_reg <= list_next[0];
            count_reg      <= COUNT_W'(cnt_next);
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign position   = position_reg;
    assign head_valid = head_valid_reg;
    assign head_floor = head_floor_reg;
    assign count      = count_reg;

endmodule

// ===== design/elevator_order_queue_unit.sv =====
// A transaction accepted at a clock edge is executed at the next edge; its result,
// with done high, is on the outputs for the one cycle that starts at that next edge.
// One transaction per cycle; the list engine finishes any operation without stalling.
// busy stays low: the back end drains the two-entry command queue every cycle, so it never
// fills; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the list and the command queue, done stays low.
module elevator_order_queue_unit
    import eoq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [FLOOR_W-1:0] floor,
    input  logic [1:0]         button,
    input  logic               moving,
    input  logic signed [1:0]  direction,
    input  logic signed [4:0]  sensor_floor,
    input  logic [FLOOR_W-1:0] last_floor,
    input  logic [FLOOR_W-1:0] dest_floor,
    output logic               done,
    output logic [2:0]         status,
    output logic [POS_W-1:0]   position,
    output logic               head_valid,
    output logic [FLOOR_W-1:0] head_floor,
    output logic [COUNT_W-1:0] count
);

    order_cmd_t in_cmd;
    order_cmd_t q_cmd;
    logic       q_full;
    logic       q_valid;

    eoq_front u_front (
        .opcode       (opcode),
        .floor        (floor),
        .button       (button),
        .moving       (moving),
        .direction    (direction),
        .sensor_floor (sensor_floor),
        .last_floor   (last_floor),
        .dest_floor   (dest_floor),
        .cmd          (in_cmd)
    );

    eoq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start),
        .push_cmd  (in_cmd),
        .pop       (q_valid),
        .full      (q_full),
        .not_empty (q_valid),
        .head_cmd  (q_cmd)
    );

    eoq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_valid),
        .cmd        (q_cmd),
        .done       (done),
        .status     (status),
        .position   (position),
        .head_valid (head_valid),
        .head_floor (head_floor),
        .count      (count)
    );

    assign busy = q_full;

endmodule

// ===== bench/tb_elevator_order_queue_unit.sv =====
module tb_elevator_order_queue_unit;
    import eoq_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int SETTLE_CYCLES = 8;

    localparam logic signed [1:0] DIR_UP = 2'sb01;
    localparam logic signed [1:0] DIR_STOP = 2'sb00;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;
    localparam logic signed [1:0] DIR_DOWN_WIDE = 2'sb10;
    localparam logic signed [4:0] UNKNOWN_FLOOR = 5'sb11111;
    localparam logic [POS_W-1:0] NO_POSITION = '1;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } idle_mode_t;

    typedef struct
    {
        opcode_t                op;
        logic [FLOOR_W-1:0]     floor;
        logic [1:0]             button;
        logic                   moving;
        logic signed [1:0]      direction;
        logic signed [4:0]      sensor_floor;
        logic [FLOOR_W-1:0]     last_floor;
        logic [FLOOR_W-1:0]     dest_floor;
    } floor_call_t;

    typedef struct
    {
        status_t                status;
        logic [POS_W-1:0]       position;
        logic                   head_valid;
        logic [FLOOR_W-1:0]     head_floor;
        logic [COUNT_W-1:0]     count;
    } list_reply_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         opcode;
    logic [FLOOR_W-1:0] floor;
    logic [1:0]         button;
    logic               moving;
    logic signed [1:0]  direction;
    logic signed [4:0]  sensor_floor;
    logic [FLOOR_W-1:0] last_floor;
    logic [FLOOR_W-1:0] dest_floor;
    logic               done;
    logic [2:0]         status;
    logic [POS_W-1:0]   position;
    logic               head_valid;
    logic [FLOOR_W-1:0] head_floor;
    logic [COUNT_W-1:0] count;

    logic [FLOOR_W-1:0] held_floors [QUEUE_DEPTH];
    int                 held_count = 0;
    list_reply_t        replies_due [$];
    floor_call_t        seen_call;
    list_reply_t        seen_reply;
    idle_mode_t         idle_mode = IDLE_FULL;

    int cycle_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int mismatch_count = 0;
    int status_tally [8];

    elevator_order_queue_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .floor        (floor),
        .button       (button),
        .moving       (moving),
        .direction    (direction),
        .sensor_floor (sensor_floor),
        .last_floor   (last_floor),
        .dest_floor   (dest_floor),
        .done         (done),
        .status       (status),
        .position     (position),
        .head_valid   (head_valid),
        .head_floor   (head_floor),
        .count        (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int locate_floor(logic [FLOOR_W-1:0] fl);
        for (int i = 0; i < held_count; i++)
        begin
            if (held_floors[i] == fl)
                return i;
        end
        return -1;
    endfunction

    function automatic void drop_floor_at(int idx);
        for (int i = idx; i + 1 < held_count; i++)
            held_floors[i] = held_floors[i + 1];
        held_floors[held_count - 1] = '0;
        held_count--;
    endfunction

    function automatic list_reply_t update_floor_list(floor_call_t c);
        list_reply_t r;
        int          hit;
        int          cur;
        int          f;
        int          tgt;
        bit          on_way;
        bit          same_dir;
        hit = -1;
        f = int'(c.floor);
        tgt = int'(c.dest_floor);
        cur = int'(c.sensor_floor);
        case (c.op)
            OP_ADD:
            begin
                if (held_count >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (c.sensor_floor == UNKNOWN_FLOOR)
                        cur = int'(c.last_floor);
                    hit = locate_floor(c.floor);
                    on_way = (c.direction > 0 && f > cur && f < tgt) ||
                             (c.direction < 0 && f < cur && f > tgt);
                    same_dir = (c.direction > 0 && c.button == BTN_UP) ||
                               (c.direction < 0 && c.button == BTN_DOWN) ||
                               c.button == BTN_CAB;
                    if (c.moving && c.direction != DIR_STOP && on_way && same_dir)
                    begin
                        if (hit >= 0)
                            drop_floor_at(hit);
                        for (int i = held_count; i > 0; i--)
                            held_floors[i] = held_floors[i - 1];
                        held_floors[0] = c.floor;
                        held_count++;
                        r.status = ST_FRONT;
                    end
                    else if (hit < 0)
                    begin
                        held_floors[held_count] = c.floor;
                        held_count++;
                        r.status = ST_APPENDED;
                    end
                    else
                        r.status = ST_DUPLICATE;
                end
            end
            OP_REMOVE:
            begin
                hit = locate_floor(c.floor);
                if (hit >= 0)
                begin
                    drop_floor_at(hit);
                    r.status = ST_REMOVED;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    held_floors[i] = '0;
                held_count = 0;
                r.status = ST_CLEARED;
            end
            default:
            begin
                hit = locate_floor(c.floor);
                r.status = (hit >= 0) ? ST_FOUND : ST_NOT_FOUND;
            end
        endcase
        r.position = (hit >= 0) ? hit[POS_W-1:0] : NO_POSITION;
        r.head_valid = (held_count > 0);
        r.head_floor = (held_count > 0) ? held_floors[0] : '0;
        r.count = held_count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, replies_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // pop the oldest prediction first, then queue the transaction of this edge
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (replies_due.size() == 0)
                report_mismatch($sformatf("result with no transaction pending, status %0d",
                                          status));
            else
            begin
                seen_reply = replies_due.pop_front();
                checked_count++;
                if (status !== seen_reply.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              status, seen_reply.status));
                if (position !== seen_reply.position)
                    report_mismatch($sformatf("position got %0d want %0d",
                                              position, seen_reply.position));
                if (head_valid !== seen_reply.head_valid)
                    report_mismatch($sformatf("head_valid got %0b want %0b",
                                              head_valid, seen_reply.head_valid));
                if (head_floor !== seen_reply.head_floor)
                    report_mismatch($sformatf("head_floor got %0d want %0d",
                                              head_floor, seen_reply.head_floor));
                if (count !== seen_reply.count)
                    report_mismatch($sformatf("count got %0d want %0d",
                                              count, seen_reply.count));
            end
        end
        if (rst_n && start && !busy)
        begin
            seen_call.op = opcode_t'(opcode);
            seen_call.floor = floor;
            seen_call.button = button;
            seen_call.moving = moving;
            seen_call.direction = direction;
            seen_call.sensor_floor = sensor_floor;
            seen_call.last_floor = last_floor;
            seen_call.dest_floor = dest_floor;
            seen_reply = update_floor_list(seen_call);
            status_tally[seen_reply.status]++;
            replies_due.push_back(seen_reply);
            accepted_count++;
        end
    end

    function automatic floor_call_t make_call(opcode_t op, int fl, button_t btn, int mv,
                                              logic signed [1:0] dir, int cur,
                                              int last, int tgt);
        floor_call_t c;
        c.op = op;
        c.floor = fl[FLOOR_W-1:0];
        c.button = btn;
        c.moving = (mv != 0);
        c.direction = dir;
        c.sensor_floor = cur[4:0];
        c.last_floor = last[FLOOR_W-1:0];
        c.dest_floor = tgt[FLOOR_W-1:0];
        return c;
    endfunction

    function automatic int next_gap();
        case (idle_mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
            default:     return $urandom_range(0, 10);
        endcase
    endfunction

    function automatic floor_call_t on_way_add();
        floor_call_t c;
        int          lo;
        int          hi;
        int          cur;
        bit          up;
        up = 1'($urandom_range(0, 1));
        lo = $urandom_range(0, 13);
        hi = $urandom_range(lo + 2, 15);
        c.op = OP_ADD;
        c.moving = ($urandom_range(0, 9) != 0);
        c.floor = FLOOR_W'($urandom_range(lo + 1, hi - 1));
        if (up)
        begin
            cur = lo;
            c.dest_floor = FLOOR_W'(hi);
            c.direction = DIR_UP;
            c.button = ($urandom_range(0, 1) == 0) ? BTN_UP : BTN_CAB;
        end
        else
        begin
            cur = hi;
            c.dest_floor = FLOOR_W'(lo);
            c.direction = ($urandom_range(0, 3) == 0) ? DIR_DOWN_WIDE : DIR_DOWN;
            c.button = ($urandom_range(0, 1) == 0) ? BTN_DOWN : BTN_CAB;
        end
        if ($urandom_range(0, 4) == 0)
            c.button = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0)
        begin
            c.sensor_floor = UNKNOWN_FLOOR;
            c.last_floor = FLOOR_W'(cur);
        end
        else
        begin
            c.sensor_floor = 5'(cur);
            c.last_floor = FLOOR_W'($urandom_range(0, 15));
        end
        return c;
    endfunction

    function automatic floor_call_t random_call();
        floor_call_t c;
        int          pick;
        pick = $urandom_range(0, 99);
        c.op = OP_ADD;
        c.floor = FLOOR_W'($urandom_range(0, 15));
        c.button = 2'($urandom_range(0, 3));
        c.moving = 1'($urandom_range(0, 1));
        c.direction = 2'($urandom_range(0, 3));
        c.sensor_floor = 5'($urandom_range(0, 31));
        c.last_floor = FLOOR_W'($urandom_range(0, 15));
        c.dest_floor = FLOOR_W'($urandom_range(0, 15));
        if (pick < 5)
            c.op = OP_CLEAR;
        else if (pick < 44)
        begin
            c.op = (pick < 25) ? OP_REMOVE : OP_FIND;
            if (held_count > 0 && $urandom_range(0, 9) < 7)
                c.floor = held_floors[$urandom_range(0, held_count - 1)];
        end
        else if (pick < 80)
            c = on_way_add();
        return c;
    endfunction

    task automatic send_call(floor_call_t c, int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode <= c.op;
        floor <= c.floor;
        button <= c.button;
        moving <= c.moving;
        direction <= c.direction;
        sensor_floor <= c.sensor_floor;
        last_floor <= c.last_floor;
        dest_floor <= c.dest_floor;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_for_replies();
        @(negedge clk);
        start <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_list();
        send_call(make_call(OP_FIND, 0, BTN_UP, 0, DIR_STOP, 0, 0, 0), next_gap());
        send_call(make_call(OP_REMOVE, 15, BTN_CAB, 1, DIR_UP, 15, 15, 15), next_gap());
        send_call(make_call(OP_CLEAR, 7, BTN_NONE, 0, DIR_DOWN, -16, 0, 0), next_gap());
    endtask

    task automatic test_fill_and_full();
        int fill_floors [QUEUE_DEPTH] = '{0, 15, 1, 2, 3, 4, 5, 6};
        foreach (fill_floors[i])
            send_call(make_call(OP_ADD, fill_floors[i], BTN_CAB, 0, DIR_UP, 0, 0, 15),
                      next_gap());
        send_call(make_call(OP_ADD, 9, BTN_UP, 1, DIR_UP, 0, 0, 15), next_gap());
        send_call(make_call(OP_FIND, 6, BTN_UP, 0, DIR_STOP, 0, 0, 0), next_gap());
        send_call(make_call(OP_REMOVE, 0, BTN_UP, 0, DIR_STOP, 0, 0, 0), next_gap());
    endtask

    task automatic test_priority_rules();
        send_call(make_call(OP_CLEAR, 0, BTN_UP, 0, DIR_STOP, 0, 0, 0), next_gap());
        send_call(make_call(OP_ADD, 5, BTN_UP, 1, DIR_UP, 2, 0, 9), next_gap());
        send_call(make_call(OP_ADD, 7, BTN_CAB, 0, DIR_UP, 2, 0, 9), next_gap());
        send_call(make_call(OP_ADD, 7, BTN_CAB, 1, DIR_UP, -1, 3, 10), next_gap());
        send_call(make_call(OP_ADD, 4, BTN_DOWN, 1, DIR_DOWN_WIDE, 9, 0, 1), next_gap());
        send_call(make_call(OP_ADD, 6, BTN_NONE, 1, DIR_UP, 2, 0, 9), next_gap());
        send_call(make_call(OP_ADD, 5, BTN_UP, 1, DIR_STOP, 2, 0, 9), next_gap());
        send_call(make_call(OP_ADD, 3, BTN_DOWN, 1, DIR_UP, 1, 0, 9), next_gap());
        send_call(make_call(OP_ADD, 10, BTN_UP, 1, DIR_UP, -5, 15, 12), next_gap());
        send_call(make_call(OP_ADD, 14, BTN_CAB, 1, DIR_UP, 0, 0, 15), next_gap());
    endtask

    task automatic test_remove_and_find();
        send_call(make_call(OP_FIND, 6, BTN_UP, 0, DIR_STOP, 0, 0, 0), next_gap());
        send_call(make_call(OP_REMOVE, 7, BTN_UP, 0, DIR_STOP, 0, 0, 0), next_gap());
        send_call(make_call(OP_REMOVE, 15, BTN_UP, 0, DIR_STOP, 0, 0, 0), next_gap());
        send_call(make_call(OP_FIND, 15, BTN_UP, 0, DIR_STOP, 0, 0, 0), next_gap());
    endtask

    task automatic test_drain_pause();
        idle_mode = IDLE_NONE;
        repeat (6)
            send_call(random_call(), next_gap());
        wait_for_replies();
        repeat (6)
            send_call(random_call(), next_gap());
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
                idle_mode = idle_mode_t'($urandom_range(0, 2));
            send_call(random_call(), next_gap());
        end
    endtask

    initial
    begin
        foreach (held_floors[i])
            held_floors[i] = '0;
        foreach (status_tally[i])
            status_tally[i] = 0;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_ADD;
        floor = '0;
        button = BTN_UP;
        moving = 1'b0;
        direction = DIR_STOP;
        sensor_floor = '0;
        last_floor = '0;
        dest_floor = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_fill_and_full();
        test_priority_rules();
        test_remove_and_find();
        test_drain_pause();
        test_random_traffic();

        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d transactions of add, remove, clear and find; %0d results checked.",
                 accepted_count, checked_count);
        $display("Front inserts %0d, duplicates %0d, full rejects %0d, mismatches %0d.",
                 status_tally[ST_FRONT], status_tally[ST_DUPLICATE],
                 status_tally[ST_FULL], mismatch_count);
        if (mismatch_count == 0 && replies_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
